/* hw/rtl/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and helpers of the go-back-n sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int WINDOW_MAX_DEF  = 32;
  localparam int SEQ_BITS_DEF    = 16;

  localparam int MAX_MSG    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_PERIOD = 4'd1;

  localparam logic [5:0]  WINDOW_SIZE_RST    = 6'd8;
  localparam logic [15:0] TIMEOUT_PERIOD_RST = 16'd20;

  typedef enum logic [1:0] {
    IN_MSG     = 2'd0,
    IN_ACK     = 2'd1,
    IN_TIMEOUT = 2'd2,
    IN_NONE    = 2'd3
  } in_kind_t;

  typedef enum logic [1:0] {
    RES_SEND  = 2'd0,
    RES_START = 2'd1,
    RES_STOP  = 2'd2,
    RES_DROP  = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    SRC_IN,
    SRC_FIFO,
    SRC_WIN
  } src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MSG_START,
    S_MSG_SEND,
    S_DROP,
    S_ACK_STOP,
    S_ACK_START,
    S_TO_START,
    S_RS_READ,
    S_RS_EMIT,
    S_DR_READ,
    S_DR_START,
    S_DR_SEND
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  length;
    logic [63:0] payload_word0;
    logic [63:0] payload_word1;
    logic [63:0] payload_word2;
    logic [63:0] payload_word3;
    logic [15:0] seq_number;
    logic [15:0] ack_number;
    logic [31:0] checksum;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind_res;
    logic [15:0] packet_seq;
    logic [5:0]  packet_length;
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [63:0] out_word3;
    logic [31:0] packet_checksum;
    logic [15:0] timer_duration;
    logic        last;
  } out_item_t;

  // stored packet: clipped payload, length and byte sum
  typedef struct packed {
    logic [255:0] words;
    logic [5:0]   len;
    logic [12:0]  bsum;
  } pkt_t;

  localparam int PKT_W = $bits(pkt_t);

  typedef struct packed {
    logic      cap;
    logic      ack_upd;
    logic      fifo_push;
    logic      fifo_pop;
    logic      win_rd;
    logic      k_inc;
    logic      commit;
    logic      emit;
    res_kind_t emit_kind;
    src_t      src;
    logic      last;
  } ctl_cmd_t;

  typedef struct packed {
    in_kind_t kind;
    logic     room;
    logic     base_eq_next;
    logic     fifo_full;
    logic     ack_ok;
    logic     drain_ok;
    logic     drain_more;
    logic     inflight_zero;
    logic     rs_last;
    logic     out_free;
  } dp_status_t;

  function automatic logic [255:0] clip_bytes(input logic [255:0] w, input logic [5:0] len);
    logic [255:0] r;
    for (int i = 0; i < MAX_MSG; i++) begin
      r[8*i +: 8] = (6'(i) < len) ? w[8*i +: 8] : 8'h00;
    end
    return r;
  endfunction

  // adder tree over the 32 payload bytes
  function automatic logic [12:0] byte_sum(input logic [255:0] w);
    logic [8:0]  l1 [16];
    logic [9:0]  l2 [8];
    logic [10:0] l3 [4];
    logic [11:0] l4 [2];
    for (int i = 0; i < 16; i++) begin
      l1[i] = 9'(w[16*i +: 8]) + 9'(w[16*i+8 +: 8]);
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = 10'(l1[2*i]) + 10'(l1[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      l3[i] = 11'(l2[2*i]) + 11'(l2[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      l4[i] = 12'(l3[2*i]) + 12'(l3[2*i+1]);
    end
    return 13'(l4[0]) + 13'(l4[1]);
  endfunction

endpackage

/* hw/rtl/gbn_in_if.sv */
// ----------------------------------------------------------------------------
// gbn_in_if
// Input channel: message, ack packet or timeout items.
// ----------------------------------------------------------------------------
interface gbn_in_if;
  logic              valid;
  logic              ready;
  gbn_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* hw/rtl/gbn_out_if.sv */
// ----------------------------------------------------------------------------
// gbn_out_if
// Result channel: send, timer and drop commands.
// ----------------------------------------------------------------------------
interface gbn_out_if;
  logic               valid;
  logic               ready;
  gbn_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

/* hw/rtl/go_back_n_sender_unit.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-back-n sender: packetizes messages, tracks acks, resends on timeout.
//
//   channel   direction  handshake      contents
//   in_ch     sink       valid/ready    message, ack packet or timeout
//   out_ch    source     valid/ready    send, start/stop timer, drop
//   cfg_*     input      write enable   window size, timeout period
//
// One item at a time: accept in idle, a decision state, then its results.
// A message after accept is queued, dropped or sent (a start timer comes
// first when none is in flight); every resent or dequeued packet takes a read
// state and then an emit state for the registered store read.
// A timeout starts the timer, then resends each packet still in flight.
// Reset clears all control state; the packet stores need no clearing.
// A stalled result register holds the sequencer in place.
// ----------------------------------------------------------------------------
module go_back_n_sender_unit #(
  parameter int QUEUE_DEPTH = gbn_pkg::QUEUE_DEPTH_DEF,
  parameter int WINDOW_MAX  = gbn_pkg::WINDOW_MAX_DEF,
  parameter int SEQ_BITS    = gbn_pkg::SEQ_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gbn_in_if.sink                         in_ch,
  gbn_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gbn_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WINDOW_MAX  (WINDOW_MAX),
    .SEQ_BITS    (SEQ_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch.item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.item)
  );

  assign in_ch.ready = in_ready;

endmodule

/* hw/rtl/gbn_ram.sv */
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int W = 8,
  parameter int D = 4,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/gbn_datapath.sv */
// ----------------------------------------------------------------------------
// gbn_datapath
// Window and queue state, packet stores, checks and the result register.
// ----------------------------------------------------------------------------
module gbn_datapath #(
  parameter int QUEUE_DEPTH = 64,
  parameter int WINDOW_MAX  = 32,
  parameter int SEQ_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gbn_pkg::in_item_t             in_item,
  input  logic                          cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  gbn_pkg::ctl_cmd_t             cmd,
  output gbn_pkg::dp_status_t           status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gbn_pkg::out_item_t            out_item
);
  import gbn_pkg::*;

  localparam int SAW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW  = $clog2(WINDOW_MAX + 1);
  localparam int FAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  logic [5:0]          ws_r;
  logic [15:0]         tp_r;
  logic [SEQ_BITS-1:0] base_r, next_r;
  logic [SAW-1:0]      slot_r;
  logic [FAW-1:0]      head_r, tail_r;
  logic [CW-1:0]       count_r;
  logic [KW-1:0]       k_r;

  in_kind_t            cap_kind_r;
  pkt_t                cap_pkt_r;
  logic [7:0]          cap_length_r;
  logic [15:0]         cap_seqf_r, cap_ackf_r;
  logic [31:0]         cap_csum_r;

  logic                out_valid_r;
  out_item_t           out_item_r;
  out_item_t           out_item_nxt;

  pkt_t                fifo_rdata, win_rdata, win_wdata, emit_pkt;
  logic [PKT_W-1:0]    fifo_rbits, win_rbits;

  logic [SEQ_BITS-1:0] inflight, ack_s, d, emit_seq;
  logic [32:0]         inflight_x, eff_x;
  logic [5:0]          eff;
  logic [31:0]         ack32, csum_calc, seq32;
  logic [SAW-1:0]      win_raddr, win_waddr, slot_nxt;
  logic [5:0]          clip_len;
  logic [255:0]        in_words, clipped;
  logic                out_free;

  function automatic logic [SAW-1:0] wrap_slot(input logic [32:0] s);
    logic [32:0] t;
    t = (s >= 33'(WINDOW_MAX)) ? s - 33'(WINDOW_MAX) : s;
    return t[SAW-1:0];
  endfunction

  // effective window
  always_comb begin
    if (ws_r == 6'd0) begin
      eff = 6'd1;
    end else if (7'(ws_r) > 7'(WINDOW_MAX)) begin
      eff = 6'(WINDOW_MAX);
    end else begin
      eff = ws_r;
    end
  end

  assign inflight   = next_r - base_r;
  assign inflight_x = 33'(inflight);
  assign eff_x      = 33'(eff);

  assign ack32     = {16'h0000, cap_ackf_r};
  assign ack_s     = ack32[SEQ_BITS-1:0];
  assign d         = ack_s - base_r;
  assign csum_calc = 32'(cap_seqf_r) + 32'(cap_ackf_r) + 32'(cap_length_r)
                   + 32'(cap_pkt_r.bsum);

  assign win_raddr = wrap_slot(33'(slot_r) + 33'(k_r));
  assign win_waddr = wrap_slot(33'(slot_r) + inflight_x);
  assign slot_nxt  = wrap_slot(33'(slot_r) + 33'(d) + 33'd1);

  // input clipping
  assign in_words = {in_item.payload_word3, in_item.payload_word2,
                     in_item.payload_word1, in_item.payload_word0};
  always_comb begin
    if (in_item.kind == IN_MSG) begin
      clip_len = (in_item.length > 8'(MAX_MSG)) ? 6'(MAX_MSG) : in_item.length[5:0];
    end else begin
      clip_len = (in_item.length <= 8'(MAX_MSG)) ? in_item.length[5:0] : 6'd0;
    end
  end
  assign clipped = clip_bytes(in_words, clip_len);

  assign out_free = !out_valid_r || out_ready;

  // status
  assign status.kind          = cap_kind_r;
  assign status.room          = inflight_x < eff_x;
  assign status.base_eq_next  = base_r == next_r;
  assign status.fifo_full     = 32'(count_r) >= 32'(QUEUE_DEPTH);
  assign status.ack_ok        = (csum_calc == cap_csum_r) && (d < inflight);
  assign status.drain_ok      = (count_r != '0) && (inflight_x < eff_x);
  assign status.drain_more    = (count_r != '0) && (inflight_x + 33'd1 < eff_x);
  assign status.inflight_zero = inflight == '0;
  assign status.rs_last       = (33'(k_r) + 33'd1) == inflight_x;
  assign status.out_free      = out_free;

  // packet stores
  assign fifo_rdata = pkt_t'(fifo_rbits);
  assign win_rdata  = pkt_t'(win_rbits);
  assign win_wdata  = (cmd.src == SRC_IN) ? cap_pkt_r : fifo_rdata;

  gbn_ram #(.W(PKT_W), .D(QUEUE_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (cmd.fifo_push),
    .waddr (tail_r),
    .wdata (cap_pkt_r),
    .re    (cmd.fifo_pop),
    .raddr (head_r),
    .rdata (fifo_rbits)
  );

  gbn_ram #(.W(PKT_W), .D(WINDOW_MAX)) u_win_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .re    (cmd.win_rd),
    .raddr (win_raddr),
    .rdata (win_rbits)
  );

  // emission source
  always_comb begin
    case (cmd.src)
      SRC_FIFO: begin
        emit_pkt = fifo_rdata;
        emit_seq = next_r;
      end
      SRC_WIN: begin
        emit_pkt = win_rdata;
        emit_seq = base_r + SEQ_BITS'(k_r);
      end
      default: begin
        emit_pkt = cap_pkt_r;
        emit_seq = next_r;
      end
    endcase
  end
  assign seq32 = 32'(emit_seq);

  // next result
  always_comb begin
    out_item_nxt          = '0;
    out_item_nxt.kind_res = cmd.emit_kind;
    out_item_nxt.last     = cmd.last;
    if (cmd.emit_kind == RES_START) begin
      out_item_nxt.timer_duration = tp_r;
    end
    if (cmd.emit_kind == RES_SEND) begin
      out_item_nxt.packet_seq      = seq32[15:0];
      out_item_nxt.packet_length   = emit_pkt.len;
      out_item_nxt.out_word0       = emit_pkt.words[63:0];
      out_item_nxt.out_word1       = emit_pkt.words[127:64];
      out_item_nxt.out_word2       = emit_pkt.words[191:128];
      out_item_nxt.out_word3       = emit_pkt.words[255:192];
      out_item_nxt.packet_checksum = seq32 + 32'(emit_pkt.len) + 32'(emit_pkt.bsum);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= WINDOW_SIZE_RST;
      tp_r        <= TIMEOUT_PERIOD_RST;
      base_r      <= '0;
      next_r      <= '0;
      slot_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == CFG_WINDOW_SIZE) begin
        ws_r <= cfg_wdata[5:0];
      end
      if (cfg_we && cfg_idx == CFG_TIMEOUT_PERIOD) begin
        tp_r <= cfg_wdata;
      end
      if (cmd.cap) begin
        k_r <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.ack_upd) begin
        slot_r <= slot_nxt;
        base_r <= ack_s + 1'b1;
      end
      if (cmd.commit) begin
        next_r <= next_r + 1'b1;
      end
      if (cmd.fifo_push) begin
        tail_r  <= (tail_r == FAW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (cmd.fifo_pop) begin
        head_r  <= (head_r == FAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
        count_r <= count_r - 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cap_kind_r     <= in_kind_t'(in_item.kind);
      cap_pkt_r      <= '{words: clipped, len: clip_len, bsum: byte_sum(clipped)};
      cap_length_r   <= in_item.length;
      cap_seqf_r     <= in_item.seq_number;
      cap_ackf_r     <= in_item.ack_number;
      cap_csum_r     <= in_item.checksum;
    end
    if (cmd.emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hw/rtl/gbn_ctrl.sv */
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer of the go-back-n sender: one input item at a time.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gbn_pkg::dp_status_t status,
  output gbn_pkg::ctl_cmd_t   cmd
);
  import gbn_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.emit_kind = RES_SEND;
    cmd.src       = SRC_IN;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (status.kind)
          IN_MSG: begin
            if (status.room) begin
              state_nxt = status.base_eq_next ? S_MSG_START : S_MSG_SEND;
            end else if (status.fifo_full) begin
              state_nxt = S_DROP;
            end else begin
              cmd.fifo_push = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          IN_ACK: begin
            if (status.ack_ok) begin
              cmd.ack_upd = 1'b1;
              state_nxt   = S_ACK_STOP;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          IN_TIMEOUT: state_nxt = S_TO_START;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_MSG_START: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_START;
          state_nxt     = S_MSG_SEND;
        end
      end
      S_MSG_SEND: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          cmd.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DROP: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_DROP;
          cmd.last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ACK_STOP: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_STOP;
          cmd.last      = status.base_eq_next && !status.drain_ok;
          if (!status.base_eq_next) begin
            state_nxt = S_ACK_START;
          end else begin
            state_nxt = status.drain_ok ? S_DR_READ : S_IDLE;
          end
        end
      end
      S_ACK_START: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_START;
          cmd.last      = !status.drain_ok;
          state_nxt     = status.drain_ok ? S_DR_READ : S_IDLE;
        end
      end
      S_TO_START: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_START;
          cmd.last      = status.inflight_zero;
          state_nxt     = status.inflight_zero ? S_IDLE : S_RS_READ;
        end
      end
      S_RS_READ: begin
        cmd.win_rd = 1'b1;
        state_nxt  = S_RS_EMIT;
      end
      S_RS_EMIT: begin
        cmd.src = SRC_WIN;
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          cmd.k_inc = 1'b1;
          cmd.last  = status.rs_last;
          state_nxt = status.rs_last ? S_IDLE : S_RS_READ;
        end
      end
      S_DR_READ: begin
        cmd.fifo_pop = 1'b1;
        state_nxt    = status.base_eq_next ? S_DR_START : S_DR_SEND;
      end
      S_DR_START: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_START;
          state_nxt     = S_DR_SEND;
        end
      end
      S_DR_SEND: begin
        cmd.src = SRC_FIFO;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          cmd.last   = !status.drain_more;
          state_nxt  = status.drain_more ? S_DR_READ : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hw/rtl/gbn_checker.sv */
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks of the go-back-n sender, bound to the top level.
// ----------------------------------------------------------------------------
module gbn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input gbn_pkg::out_item_t out_item
);
  import gbn_pkg::*;

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // only send results carry packet fields
  a_pkt_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind_res != RES_SEND |->
      out_item.packet_length == 6'd0 && out_item.packet_checksum == 32'd0)
    else $error("packet fields on a non-send result");

  a_timer_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind_res != RES_START |-> out_item.timer_duration == 16'd0)
    else $error("timer duration on a non-start result");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind go_back_n_sender_unit gbn_checker u_gbn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.item)
);
